[hw/rtl/spphs_pkg.sv]
// Shared types and constants for the string-pair hash presence set.
// Used by the front, queue, back and top-level modules; depends on nothing.
package spphs_pkg;

	localparam int unsigned ENTRY_INDEX_W = 10;
	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned SUM_W         = 32;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QUEUE_AW      = 2;

	localparam logic [SUM_W-1:0]  HASH_MULT   = 32'd61;
	localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
	localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;
	localparam logic STR_NAME   = 1'b0;
	localparam logic STR_SCOPE  = 1'b1;

	typedef struct packed {
		logic                     lookup;
		logic [ENTRY_INDEX_W-1:0] idx;
	} spphs_op_t;

endpackage

[hw/rtl/spphs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the presence table.
module spphs_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 999
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/spphs_front.sv]
// Front end: accepts characters, folds case, updates the string accumulators
// and reduces a finished accumulator to its slot. Depends on spphs_pkg.
module spphs_front #(
	parameter int unsigned HASH_MODULUS = 500
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	output logic                              ready,
	input  logic                              command,
	input  logic                              which_string,
	input  logic [spphs_pkg::CHAR_W-1:0]      character,
	output logic                              push_valid,
	input  logic                              push_ready,
	output spphs_pkg::spphs_op_t              push_op
);

	localparam int unsigned SLOT_W = $clog2(HASH_MODULUS);
	localparam int unsigned IDX_W  = SLOT_W + 1;
	localparam int unsigned PROD_W = 2 * spphs_pkg::SUM_W;
	localparam logic [SLOT_W:0] MOD_V = (SLOT_W + 1)'(HASH_MODULUS);
	localparam logic [spphs_pkg::SUM_W-1:0] MOD_W = spphs_pkg::SUM_W'(HASH_MODULUS);
	// Reciprocal of the modulus scaled by 2^32, rounded down.
	localparam logic [spphs_pkg::SUM_W-1:0] RECIP =
		spphs_pkg::SUM_W'((64'd1 << spphs_pkg::SUM_W) / HASH_MODULUS);

	typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUB, F_FIX, F_PUSH} state_t;

	state_t                           state_q;
	logic [spphs_pkg::SUM_W-1:0]      name_sum_q;
	logic [spphs_pkg::SUM_W-1:0]      scope_sum_q;
	logic [SLOT_W-1:0]                name_slot_q;
	logic [spphs_pkg::SUM_W-1:0]      div_q;
	logic [spphs_pkg::SUM_W-1:0]      quot_q;
	logic [SLOT_W:0]                  diff_q;
	logic [SLOT_W-1:0]                rem_q;
	logic                             scope_q;
	logic                             cmd_q;

	logic [spphs_pkg::CHAR_W-1:0]     folded;
	logic [spphs_pkg::SUM_W-1:0]      ext_char;
	logic [spphs_pkg::SUM_W-1:0]      sel_sum;
	logic [spphs_pkg::SUM_W-1:0]      mac;
	logic [spphs_pkg::SUM_W-1:0]      term_val;
	logic [spphs_pkg::SUM_W-1:0]      term_mag;
	logic [PROD_W-1:0]                prod;
	logic [spphs_pkg::SUM_W-1:0]      quot_times_mod;
	logic [spphs_pkg::SUM_W-1:0]      diff;
	logic [SLOT_W-1:0]                rem_fix;
	logic [IDX_W-1:0]                 idx_sum;

	always_comb begin
		folded = character;
		if (character inside {[spphs_pkg::UPPER_FIRST:spphs_pkg::UPPER_LAST]}) begin
			folded = character + spphs_pkg::CASE_OFFSET;
		end
		ext_char = {{(spphs_pkg::SUM_W - spphs_pkg::CHAR_W){folded[spphs_pkg::CHAR_W-1]}},
			folded};
		sel_sum  = (which_string == spphs_pkg::STR_SCOPE) ? scope_sum_q : name_sum_q;
		mac      = sel_sum * spphs_pkg::HASH_MULT + ext_char;
		// A name slot is taken from the accumulator plus one.
		term_val = (which_string == spphs_pkg::STR_SCOPE) ? scope_sum_q
			: name_sum_q + spphs_pkg::SUM_W'(1);
		// The most negative value negates to itself, which read unsigned is 2^31.
		term_mag = term_val[spphs_pkg::SUM_W-1] ? (~term_val + spphs_pkg::SUM_W'(1))
			: term_val;
		// The quotient estimate from the scaled reciprocal is at most one low, so
		// the remainder left after the subtract is below twice the modulus.
		prod           = PROD_W'(div_q) * PROD_W'(RECIP);
		quot_times_mod = quot_q * MOD_W;
		diff           = div_q - quot_times_mod;
		rem_fix        = (diff_q >= MOD_V) ? SLOT_W'(diff_q - MOD_V) : diff_q[SLOT_W-1:0];
		idx_sum        = {1'b0, name_slot_q} + {1'b0, rem_q};
	end

	assign ready          = (state_q == F_IDLE);
	assign push_valid     = (state_q == F_PUSH);
	assign push_op.lookup = (cmd_q == spphs_pkg::CMD_LOOKUP);
	assign push_op.idx    = spphs_pkg::ENTRY_INDEX_W'(idx_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			name_sum_q  <= '0;
			scope_sum_q <= '0;
			name_slot_q <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			diff_q      <= '0;
			scope_q     <= 1'b0;
			cmd_q       <= 1'b0;
			div_q       <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						if (character != '0) begin
							if (which_string == spphs_pkg::STR_SCOPE) begin
								scope_sum_q <= mac;
							end else begin
								name_sum_q <= mac;
							end
						end else begin
							if (which_string == spphs_pkg::STR_SCOPE) begin
								scope_sum_q <= '0;
							end else begin
								name_sum_q <= '0;
							end
							div_q   <= term_mag;
							scope_q <= which_string;
							cmd_q   <= command;
							state_q <= F_MUL;
						end
					end
				end
				F_MUL: begin
					quot_q  <= prod[PROD_W-1:spphs_pkg::SUM_W];
					state_q <= F_SUB;
				end
				F_SUB: begin
					diff_q  <= diff[SLOT_W:0];
					state_q <= F_FIX;
				end
				F_FIX: begin
					if (scope_q == spphs_pkg::STR_SCOPE) begin
						rem_q   <= rem_fix;
						state_q <= F_PUSH;
					end else begin
						name_slot_q <= rem_fix;
						state_q     <= F_IDLE;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/spphs_fifo.sv]
// Short queue of table operations between the front and back ends.
// Depends on spphs_pkg for the operation type and depth.
module spphs_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  spphs_pkg::spphs_op_t push_op,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output spphs_pkg::spphs_op_t pop_op
);

	spphs_pkg::spphs_op_t              mem_q [spphs_pkg::QUEUE_DEPTH];
	logic [spphs_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [spphs_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [spphs_pkg::QUEUE_AW:0]      count_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (count_q != (spphs_pkg::QUEUE_AW + 1)'(spphs_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/spphs_back.sv]
// Back end: clears the presence table after reset, then marks entries and
// answers lookups through an output register. Depends on spphs_pkg, spphs_ram.
module spphs_back #(
	parameter int unsigned HASH_MODULUS = 500
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 op_valid,
	output logic                                 op_pop,
	input  spphs_pkg::spphs_op_t                 op,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [spphs_pkg::ENTRY_INDEX_W-1:0]  entry_index
);

	localparam int unsigned DEPTH = 2 * HASH_MODULUS - 1;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef enum logic [1:0] {B_CLEAR, B_RUN, B_READ} state_t;

	state_t                               state_q;
	logic [AW-1:0]                        clr_q;
	logic [spphs_pkg::ENTRY_INDEX_W-1:0]  idx_q;
	logic                                 out_valid_q;
	logic                                 found_q;
	logic [spphs_pkg::ENTRY_INDEX_W-1:0]  entry_index_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic          wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic          rdata;
	logic          load;

	assign load = (state_q == B_READ) && (!out_valid_q || out_ready);

	always_comb begin
		we     = 1'b0;
		waddr  = op.idx[AW-1:0];
		wdata  = 1'b1;
		re     = 1'b0;
		raddr  = op.idx[AW-1:0];
		op_pop = 1'b0;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 1'b0;
			end
			B_RUN: begin
				if (op_valid) begin
					op_pop = 1'b1;
					if (op.lookup) begin
						re = 1'b1;
					end else begin
						we = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	spphs_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_CLEAR;
			clr_q         <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			entry_index_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (op_valid && op.lookup) begin
						idx_q   <= op.idx;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					// The RAM holds its read data until the next read, so a stalled
					// output simply waits here.
					if (load) begin
						out_valid_q   <= 1'b1;
						found_q       <= rdata;
						entry_index_q <= idx_q;
						state_q       <= B_RUN;
					end
				end
				default: begin
					state_q <= B_RUN;
				end
			endcase
		end
	end

	assign clearing    = (state_q == B_CLEAR);
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign entry_index = entry_index_q;

endmodule

[hw/rtl/string_pair_hash_presence_set_core.sv]
// String-pair hash presence set, top level. Depends on spphs_pkg and its submodules.
// Operation: a character transfer only updates its accumulator; a terminator
// holds the input through the reciprocal multiply, subtract and one correction, and a scope
// terminator also while its table operation is queued, which waits on a full queue. No new
// character is taken until that reduction is done.
// Reset: asynchronous; then every table entry is cleared while no input is taken.
module string_pair_hash_presence_set_core #(
	parameter int unsigned HASH_MODULUS = 500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] character
	input  logic [1:0]  s_axis_tuser,  // [0] command, [1] which_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] found, [10:1] entry_index, [15:11] zero
);

	logic                                 front_ready;
	logic                                 clearing;
	logic                                 take;
	logic                                 push_valid;
	logic                                 push_ready;
	spphs_pkg::spphs_op_t                 push_op;
	logic                                 pop_valid;
	logic                                 pop_ready;
	spphs_pkg::spphs_op_t                 pop_op;
	logic                                 found;
	logic [spphs_pkg::ENTRY_INDEX_W-1:0]  entry_index;

	assign s_axis_tready = front_ready && !clearing;
	assign take          = s_axis_tvalid && s_axis_tready;

	spphs_front #(
		.HASH_MODULUS (HASH_MODULUS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.ready        (front_ready),
		.command      (s_axis_tuser[0]),
		.which_string (s_axis_tuser[1]),
		.character    (s_axis_tdata),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_op      (push_op)
	);

	spphs_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	spphs_back #(
		.HASH_MODULUS (HASH_MODULUS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (pop_valid),
		.op_pop      (pop_ready),
		.op          (pop_op),
		.clearing    (clearing),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.found       (found),
		.entry_index (entry_index)
	);

	assign m_axis_tdata = {5'b0, entry_index, found};

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !clearing)
		else $error("result presented before the table clear finished");

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop_ready)
		else $error("table operation taken during the clear pass");

	a_input_blocked_while_pushing: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !s_axis_tready)
		else $error("input transfer taken while a table operation waits");

endmodule
